// File: rtl/qpsa_pkg.sv
// shared widths, codes and types for the qudit pauli string block
package qpsa_pkg;

  localparam int IDX_W     = 13;
  localparam int AMP_W     = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = AMP_W + COEF_W;
  localparam int NQ_W      = 4;
  localparam int OPS_W     = 16;
  localparam int OP_W      = 2;
  localparam int OPS_QUDITS = OPS_W / OP_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [AMP_W-1:0] amp_t;
  typedef logic [OP_W-1:0]         op_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  // per-qudit operator codes
  localparam op_t OP_ID = 2'd0;
  localparam op_t OP_X  = 2'd1;
  localparam op_t OP_Y  = 2'd2;
  localparam op_t OP_Z  = 2'd3;

  // register indexes
  localparam cfg_idx_t CFG_NUM_QUDITS = 2'd0;
  localparam cfg_idx_t CFG_OP_CODES   = 2'd1;

  localparam logic [NQ_W-1:0]  NQ_RESET  = 4'd8;
  localparam logic [OPS_W-1:0] OPS_RESET = 16'd0;

endpackage

// File: rtl/qpsa_in_if.sv
// input channel: source index and amplitude
interface qpsa_in_if;
  logic          valid;
  logic          ready;
  qpsa_pkg::idx_t source_index;
  qpsa_pkg::amp_t amp_re;
  qpsa_pkg::amp_t amp_im;

  modport source (output valid, output source_index, output amp_re, output amp_im,
                  input ready);
  modport sink   (input valid, input source_index, input amp_re, input amp_im,
                  output ready);
endinterface

// File: rtl/qpsa_out_if.sv
// output channel: target index, phased amplitude and error flag
interface qpsa_out_if;
  logic          valid;
  logic          ready;
  qpsa_pkg::idx_t target_index;
  qpsa_pkg::amp_t out_re;
  qpsa_pkg::amp_t out_im;
  logic          index_error;

  modport source (output valid, output target_index, output out_re, output out_im,
                  output index_error, input ready);
  modport sink   (input valid, input target_index, input out_re, input out_im,
                  input index_error, output ready);
endinterface

// File: rtl/qudit_pauli_string_apply.sv
// top level: generalized qudit pauli string applied to a stream of amplitudes
//
// Takes one transaction per cycle while the output side does not stall, and
// returns one per transaction, in order, from a pipeline of registered stages.
// The pipeline has one stage per base-RADIX digit (least significant digit
// first), each peeling one digit off the index with a reciprocal multiply,
// applying that qudit's operator to the digit and folding it into the target
// index and the phase exponent; a stage then reads the phase table and forms
// the four partial products, and the last stage rounds to nearest, saturates
// and holds the result. Each stage has its own valid bit and takes a new
// transaction whenever it is empty or its successor moves, so bubbles close up
// and a stalled output never drops or duplicates anything. An index at or
// above RADIX^num_qudits comes out with index_error set and zero target and
// amplitude. num_qudits of zero acts as one, above MAX_QUDITS as MAX_QUDITS;
// qudits past the eighth have no opcode and act as identity. Registers are
// written through cfg_we/cfg_index/cfg_data and should only change while the
// pipeline is empty.
module qudit_pauli_string_apply #(
  parameter int RADIX      = 3,
  parameter int MAX_QUDITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  qpsa_pkg::cfg_idx_t             cfg_index,
  input  logic [qpsa_pkg::CFG_W-1:0]     cfg_data,
  qpsa_in_if.sink                        src,
  qpsa_out_if.source                     dst
);

  localparam int IDX_W  = qpsa_pkg::IDX_W;
  localparam int COEF_W = qpsa_pkg::COEF_W;
  localparam int PROD_W = qpsa_pkg::PROD_W;
  localparam int DW     = (RADIX > 2) ? $clog2(RADIX) : 1;  // digit / exponent width
  localparam int NW     = $clog2(MAX_QUDITS + 1);
  localparam int NS     = MAX_QUDITS + 2;                   // pipeline stages
  localparam int PS     = MAX_QUDITS;                       // product stage
  localparam int OS     = MAX_QUDITS + 1;                   // output stage

  // divide by RADIX: multiply by rounded-up reciprocal, exact for IDX_W-bit values
  localparam int SH = IDX_W + $clog2(RADIX);
  localparam longint RECIP = ((64'd1 << SH) + RADIX - 1) / RADIX;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // phase table, Q2.14, entry k holds cos or sin of 2*pi*k/RADIX
  function automatic logic [COEF_W*RADIX-1:0] build_rom(input logic want_im);
    logic [COEF_W*RADIX-1:0] rom;
    longint unsigned q, r, x, x2, tc, ts;
    longint sc, ss, cr, sr, v, mag, rr;
    rom = '0;
    for (int k = 0; k < RADIX; k++) begin
      q  = (4 * k) / RADIX;
      r  = (4 * k) % RADIX;
      x  = PI_HALF_Q30 * r / RADIX;
      x2 = (x * x) >> 30;
      tc = 64'd1 << 30;
      ts = x;
      sc = longint'(tc);
      ss = longint'(ts);
      for (int j = 1; j <= 10; j++) begin
        tc = (tc * x2) >> 30;
        ts = (ts * x2) >> 30;
        // taylor term divisors: (2j-1)(2j) for cosine, (2j)(2j+1) for sine
        unique case (j)
          1:       begin tc = tc / 64'd2;   ts = ts / 64'd6;   end
          2:       begin tc = tc / 64'd12;  ts = ts / 64'd20;  end
          3:       begin tc = tc / 64'd30;  ts = ts / 64'd42;  end
          4:       begin tc = tc / 64'd56;  ts = ts / 64'd72;  end
          5:       begin tc = tc / 64'd90;  ts = ts / 64'd110; end
          6:       begin tc = tc / 64'd132; ts = ts / 64'd156; end
          7:       begin tc = tc / 64'd182; ts = ts / 64'd210; end
          8:       begin tc = tc / 64'd240; ts = ts / 64'd272; end
          9:       begin tc = tc / 64'd306; ts = ts / 64'd342; end
          default: begin tc = tc / 64'd380; ts = ts / 64'd420; end
        endcase
        if ((j % 2) == 1) begin
          sc = sc - longint'(tc);
          ss = ss - longint'(ts);
        end else begin
          sc = sc + longint'(tc);
          ss = ss + longint'(ts);
        end
      end
      case (q % 4)
        0:       begin cr = sc;  sr = ss;  end
        1:       begin cr = -ss; sr = sc;  end
        2:       begin cr = -sc; sr = -ss; end
        default: begin cr = ss;  sr = -sc; end
      endcase
      v   = want_im ? sr : cr;
      mag = (v < 0) ? -v : v;
      rr  = (mag + 32768) >>> 16;
      v   = (v < 0) ? -rr : rr;
      rom[k*COEF_W +: COEF_W] = v[COEF_W-1:0];
    end
    return rom;
  endfunction

  // RADIX^k modulo 2^IDX_W, the weight of digit k in the target index
  function automatic logic [IDX_W-1:0] pow_mod(input int k);
    logic [IDX_W-1:0] p;
    p = IDX_W'(1);
    for (int i = 0; i < k; i++) p = IDX_W'(p * RADIX);
    return p;
  endfunction

  localparam logic [COEF_W*RADIX-1:0] ROM_RE = build_rom(1'b0);
  localparam logic [COEF_W*RADIX-1:0] ROM_IM = build_rom(1'b1);

  // round to nearest (floor of value plus half lsb) and saturate to Q1.15
  function automatic qpsa_pkg::amp_t round_sat(input logic signed [PROD_W:0] s);
    logic signed [PROD_W:0] t;
    logic signed [PROD_W-14:0] r;
    t = s + (PROD_W+1)'(8192);
    r = t[PROD_W:14];
    if (r > (PROD_W-13)'(32767))       return 16'sh7fff;
    else if (r < -(PROD_W-13)'(32768)) return 16'sh8000;
    else                               return r[15:0];
  endfunction

  // configuration registers
  logic [qpsa_pkg::NQ_W-1:0]  num_qudits;
  logic [qpsa_pkg::OPS_W-1:0] op_codes;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_qudits <= qpsa_pkg::NQ_RESET;
      op_codes   <= qpsa_pkg::OPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qpsa_pkg::CFG_NUM_QUDITS: num_qudits <= cfg_data[qpsa_pkg::NQ_W-1:0];
        qpsa_pkg::CFG_OP_CODES:   op_codes   <= cfg_data[qpsa_pkg::OPS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped qudit count
  logic [NW-1:0] n_eff;
  always_comb begin
    if (num_qudits == '0)                   n_eff = NW'(1);
    else if (int'(num_qudits) > MAX_QUDITS) n_eff = NW'(MAX_QUDITS);
    else                                    n_eff = NW'(num_qudits);
  end

  // pipeline handshake: a stage moves when empty or when its successor moves
  logic [NS-1:0] v;
  logic [NS:0]   adv;

  assign adv[NS] = dst.ready;
  for (genvar j = 0; j < NS; j++) begin : g_adv
    assign adv[j] = ~v[j] | adv[j+1];
  end
  assign src.ready = adv[0];

  // digit stage registers
  qpsa_pkg::idx_t quo   [MAX_QUDITS];   // index still to be split
  qpsa_pkg::idx_t tgt   [MAX_QUDITS];   // target index so far
  logic [DW-1:0]  ex    [MAX_QUDITS];   // phase exponent so far
  logic           err   [MAX_QUDITS];
  qpsa_pkg::amp_t ar    [MAX_QUDITS];
  qpsa_pkg::amp_t ai    [MAX_QUDITS];

  for (genvar k = 0; k < MAX_QUDITS; k++) begin : g_dig
    localparam logic [IDX_W-1:0] WEIGHT = pow_mod(k);

    qpsa_pkg::idx_t      q_in, t_in, q_next, rem, t_next;
    logic [DW-1:0]       e_in, d, nd, e_next;
    logic [DW:0]         e_sum;
    logic                err_in, err_next, v_in;
    qpsa_pkg::amp_t      ar_in, ai_in;
    logic [IDX_W+SH:0]   prod;
    logic [NW-1:0]       qi;
    qpsa_pkg::op_t       op;

    if (k == 0) begin : g_first
      assign v_in   = src.valid;
      assign q_in   = src.source_index;
      assign t_in   = '0;
      assign e_in   = '0;
      assign err_in = 1'b0;
      assign ar_in  = src.amp_re;
      assign ai_in  = src.amp_im;
    end else begin : g_next
      assign v_in   = v[k-1];
      assign q_in   = quo[k-1];
      assign t_in   = tgt[k-1];
      assign e_in   = ex[k-1];
      assign err_in = err[k-1];
      assign ar_in  = ar[k-1];
      assign ai_in  = ai[k-1];
    end

    always_comb begin
      // digit k (least significant first) belongs to qudit n_eff-1-k
      prod   = (IDX_W+SH+1)'(q_in) * (IDX_W+SH+1)'(RECIP);
      q_next = prod[SH +: IDX_W];
      rem    = q_in - IDX_W'(q_next * RADIX);
      d      = rem[DW-1:0];
      qi     = n_eff - NW'(k + 1);
      op     = qpsa_pkg::OP_ID;
      if (k < int'(n_eff)) begin
        for (int i = 0; i < qpsa_pkg::OPS_QUDITS; i++) begin
          if (int'(qi) == i) op = op_codes[2*i +: 2];
        end
      end
      // phase exponent modulo RADIX
      e_sum = {1'b0, e_in} + {1'b0, d};
      if (e_sum >= (DW+1)'(RADIX)) e_sum = e_sum - (DW+1)'(RADIX);
      e_next = (op == qpsa_pkg::OP_Y || op == qpsa_pkg::OP_Z) ? e_sum[DW-1:0] : e_in;
      // shifted digit
      if (op == qpsa_pkg::OP_X || op == qpsa_pkg::OP_Y)
        nd = (d == DW'(RADIX - 1)) ? '0 : DW'(d + 1'b1);
      else
        nd = d;
      t_next = t_in + IDX_W'(nd * WEIGHT);
      // out of range when digits remain above the top qudit in use
      err_next = (k == int'(n_eff) - 1) ? (q_next != '0) : err_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv[k]) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        quo[k] <= q_next;
        tgt[k] <= t_next;
        ex[k]  <= e_next;
        err[k] <= err_next;
        ar[k]  <= ar_in;
        ai[k]  <= ai_in;
      end
    end
  end

  // product stage: phase lookup and four partial products
  logic signed [COEF_W-1:0] cr, ci;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  qpsa_pkg::idx_t           p_tgt;
  logic                     p_err;

  assign cr = ROM_RE[ex[PS-1]*COEF_W +: COEF_W];
  assign ci = ROM_IM[ex[PS-1]*COEF_W +: COEF_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[PS] <= 1'b0;
    end else if (adv[PS]) begin
      v[PS] <= v[PS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[PS]) begin
      p_rr  <= ar[PS-1] * cr;
      p_ii  <= ai[PS-1] * ci;
      p_ri  <= ar[PS-1] * ci;
      p_ir  <= ai[PS-1] * cr;
      p_tgt <= tgt[PS-1];
      p_err <= err[PS-1];
    end
  end

  // output stage: sums, rounding, saturation and the held result
  logic signed [PROD_W:0] s_re, s_im;
  qpsa_pkg::idx_t         o_tgt;
  qpsa_pkg::amp_t         o_re, o_im;
  logic                   o_err;

  assign s_re = {p_rr[PROD_W-1], p_rr} - {p_ii[PROD_W-1], p_ii};
  assign s_im = {p_ri[PROD_W-1], p_ri} + {p_ir[PROD_W-1], p_ir};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[OS] <= 1'b0;
    end else if (adv[OS]) begin
      v[OS] <= v[PS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OS]) begin
      o_err <= p_err;
      if (p_err) begin
        o_tgt <= '0;
        o_re  <= '0;
        o_im  <= '0;
      end else begin
        o_tgt <= p_tgt;
        o_re  <= round_sat(s_re);
        o_im  <= round_sat(s_im);
      end
    end
  end

  assign dst.valid        = v[OS];
  assign dst.target_index = o_tgt;
  assign dst.out_re       = o_re;
  assign dst.out_im       = o_im;
  assign dst.index_error  = o_err;

endmodule
